@@ rtl/asws_pkg.sv @@
// Shared types and constants for the approximate sliding-window sum.
// Used by the interfaces, the front end, the back end and the top module; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package asws_pkg;

    // Field widths
    localparam int SIZE_W     = 16;
    localparam int XW         = 17;    // normalised item, up to 2^16
    localparam int V_W        = 5;
    localparam int LEN_REG_W  = 11;
    localparam int RES_W      = 26;
    localparam int TOT_W      = 27;    // residual plus one item
    localparam int CNT_W      = 18;
    localparam int EST_W      = 27;
    localparam int THR_W      = 27;
    localparam int PROD_W     = THR_W + CNT_W;
    localparam int LEN_W      = 17;    // common width for length compares
    localparam int RING_DEPTH = 1024;
    localparam int RING_AW    = 10;
    localparam int MAX_LEN    = 1024;
    localparam int MAX_V      = 16;

    localparam logic [RES_W-1:0] RES_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [EST_W-1:0] EST_MAX = '1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_RANGE_MAX       = 3'd0;
    localparam cfg_idx_t CFG_PRECISION_BITS  = 3'd1;
    localparam cfg_idx_t CFG_LARGE_MODE      = 3'd2;
    localparam cfg_idx_t CFG_BLOCK_LEN       = 3'd3;
    localparam cfg_idx_t CFG_RING_LEN        = 3'd4;
    localparam cfg_idx_t CFG_BLOCK_THRESHOLD = 3'd5;
    localparam cfg_idx_t CFG_WINDOW_LEN      = 3'd6;

    typedef struct packed {
        logic [15:0] range_max;
        logic [4:0]  precision_bits;
        logic        large_mode;
        logic [10:0] block_len;
        logic [10:0] ring_len;
        logic [26:0] block_threshold;
        logic [10:0] window_len;
    } cfg_t;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_DIV,
        FE_PUSH
    } fe_state_t;

    typedef enum logic [2:0] {
        BE_CLEAR,
        BE_IDLE,
        BE_LOOK,
        BE_DIV,
        BE_FIN,
        BE_MUL,
        BE_EST
    } be_state_t;

endpackage

`default_nettype wire

@@ rtl/asws_if.sv @@
// Valid/ready channel interfaces for packet sizes in and results out.
// Depends on asws_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface asws_in_if;
    logic                          valid;
    logic                          ready;
    logic [asws_pkg::SIZE_W-1:0]   packet_size;

    modport source (output valid, output packet_size, input ready);
    modport sink   (input valid, input packet_size, output ready);
endinterface

interface asws_out_if;
    logic                          valid;
    logic                          ready;
    logic [asws_pkg::CNT_W-1:0]    block_count;
    logic [asws_pkg::RES_W-1:0]    residual;
    logic [asws_pkg::EST_W-1:0]    estimate;

    modport source (output valid, output block_count, output residual, output estimate,
                    input ready);
    modport sink   (input valid, input block_count, input residual, input estimate,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/asws_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module asws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/asws_front.sv @@
// Front end: takes packet sizes and normalises them to round(size*2^v/range), capped at 2^v.
// Depends on asws_pkg and asws_if; one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module asws_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    asws_in_if.sink                    in_ch,
    input  wire asws_pkg::cfg_t        cfg,
    input  wire logic                  hold,
    output logic                       push_valid,
    output logic [asws_pkg::XW-1:0]    push_data,
    input  wire logic                  push_ready
);

    localparam int NUM_W  = 32;
    localparam int STEP_W = 5;

    asws_pkg::fe_state_t state_reg, state_next;
    logic [NUM_W-1:0]        rem_reg, rem_next;
    logic [NUM_W-1:0]        dsor_reg, dsor_next;
    logic [asws_pkg::XW-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0]       step_reg, step_next;

    logic [15:0]             rng;
    logic [asws_pkg::V_W-1:0] v;
    logic [NUM_W-1:0]        num;
    logic [asws_pkg::XW-1:0] one;
    logic                    sat_hit;
    logic                    ge;

    // Clamp the normaliser and the precision
    assign rng = (cfg.range_max == 16'd0) ? 16'd1 : cfg.range_max;
    assign v   = (cfg.precision_bits == '0) ? asws_pkg::V_W'(1) :
                 (cfg.precision_bits > asws_pkg::V_W'(asws_pkg::MAX_V)) ?
                 asws_pkg::V_W'(asws_pkg::MAX_V) : cfg.precision_bits;

    // Numerator with half-up rounding term
    assign num     = (NUM_W'(in_ch.packet_size) << v) + NUM_W'(rng >> 1);
    assign one     = asws_pkg::XW'(1) << v;
    assign sat_hit = {1'b0, num} >= ((NUM_W + 1)'(rng) << asws_pkg::XW);
    assign ge      = rem_reg >= dsor_reg;

    assign in_ch.ready = (state_reg == asws_pkg::FE_IDLE) && !hold;
    assign push_valid  = (state_reg == asws_pkg::FE_PUSH);
    assign push_data   = (quo_reg > one) ? one : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= asws_pkg::FE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsor_reg <= dsor_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

    // Restoring divider sequence
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        dsor_next  = dsor_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        case (state_reg)
            asws_pkg::FE_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    if (sat_hit)
                    begin
                        quo_next   = one;
                        state_next = asws_pkg::FE_PUSH;
                    end
                    else
                    begin
                        rem_next   = num;
                        dsor_next  = NUM_W'(rng) << (asws_pkg::XW - 1);
                        quo_next   = '0;
                        step_next  = STEP_W'(asws_pkg::XW - 1);
                        state_next = asws_pkg::FE_DIV;
                    end
                end
            end
            asws_pkg::FE_DIV:
            begin
                if (ge)
                begin
                    rem_next = rem_reg - dsor_reg;
                end
                quo_next  = {quo_reg[asws_pkg::XW-2:0], ge};
                dsor_next = dsor_reg >> 1;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = asws_pkg::FE_PUSH;
                end
            end
            asws_pkg::FE_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = asws_pkg::FE_IDLE;
                end
            end
            default:
            begin
                state_next = asws_pkg::FE_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/asws_queue.sv @@
// Two-entry queue between the normalising front end and the window back end.
// Depends on nothing but its width parameter.
`timescale 1ns / 1ps
`default_nettype none

module asws_queue #(
    parameter int WIDTH = 17
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  push_ready,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  pop_valid
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/asws_back.sv @@
// Back end: residual update, block ring or quotient line, count and estimate.
// Depends on asws_pkg, asws_if and asws_ram.
`timescale 1ns / 1ps
`default_nettype none

module asws_back #(
    parameter int WINDOW        = 1024,
    parameter int QUOTIENT_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire asws_pkg::cfg_t        cfg,
    input  wire logic                  x_valid,
    input  wire logic [asws_pkg::XW-1:0] x_data,
    output logic                       x_pop,
    asws_out_if.source                 out_ch,
    output logic                       clearing
);

    localparam int QW        = QUOTIENT_BITS;
    localparam int LINE_AW   = $clog2(WINDOW);
    localparam int CLR_DEPTH = (WINDOW > asws_pkg::RING_DEPTH) ? WINDOW : asws_pkg::RING_DEPTH;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);
    localparam longint CNT_BOUND = longint'(asws_pkg::RING_DEPTH)
                                 + ((64'd1 << QW) - 64'd1) * longint'(WINDOW);
    localparam int COUNT_W   = $clog2(CNT_BOUND + 64'd1);
    localparam int CNT_EXT_W = (COUNT_W > asws_pkg::CNT_W) ? COUNT_W : asws_pkg::CNT_W;
    localparam int DV_W      = asws_pkg::THR_W + QW;
    localparam int SW        = (QW > 1) ? $clog2(QW) : 1;
    localparam int LEN_W     = asws_pkg::LEN_W;
    localparam int L11       = asws_pkg::LEN_REG_W;

    asws_pkg::be_state_t state_reg, state_next;

    logic [COUNT_W-1:0]          count_reg, count_next;
    logic [asws_pkg::RES_W-1:0]  res_reg, res_next;
    logic [asws_pkg::TOT_W-1:0]  rem_reg, rem_next;
    logic [DV_W-1:0]             dsor_reg, dsor_next;
    logic [QW-1:0]               quo_reg, quo_next;
    logic [SW-1:0]               step_reg, step_next;
    logic [L11-1:0]              item_reg, item_next;
    logic [asws_pkg::RING_AW-1:0] ring_pos_reg, ring_pos_next;
    logic [LINE_AW-1:0]          line_pos_reg, line_pos_next;
    logic [CLR_AW-1:0]           clr_reg, clr_next;
    logic [asws_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic                        out_valid_reg, out_valid_next;
    logic [asws_pkg::CNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic [asws_pkg::RES_W-1:0]  out_res_reg, out_res_next;
    logic [asws_pkg::EST_W-1:0]  out_est_reg, out_est_next;

    logic [asws_pkg::V_W-1:0]    v;
    logic [L11-1:0]              bl, rl;
    logic [LEN_W-1:0]            wl;
    logic [asws_pkg::THR_W-1:0]  thr;
    logic [DV_W-1:0]             thr_sh;
    logic [asws_pkg::RING_AW-1:0] ring_p, ring_pos_nx;
    logic [L11-1:0]              ring_inc;
    logic [LINE_AW-1:0]          line_p, line_pos_nx;
    logic [LEN_W-1:0]            line_inc;
    logic [asws_pkg::TOT_W-1:0]  tot;
    logic [asws_pkg::RES_W-1:0]  res_add_sat;
    logic [L11-1:0]              item_inc;
    logic                        closing;
    logic                        blk_bit;
    logic [CNT_EXT_W-1:0]        cnt_ext;
    logic [asws_pkg::CNT_W-1:0]  cnt_sat;
    logic [asws_pkg::PROD_W:0]   est_sum;
    logic                        div_ge;
    logic                        out_free;
    logic                        clr_ring, clr_line;

    logic                        ring_we;
    logic [asws_pkg::RING_AW-1:0] ring_waddr;
    logic                        ring_wdata, ring_rdata;
    logic                        line_we;
    logic [LINE_AW-1:0]          line_waddr;
    logic [QW-1:0]               line_wdata, line_rdata;

    // Clamped configuration
    assign v  = (cfg.precision_bits == '0) ? asws_pkg::V_W'(1) :
                (cfg.precision_bits > asws_pkg::V_W'(asws_pkg::MAX_V)) ?
                asws_pkg::V_W'(asws_pkg::MAX_V) : cfg.precision_bits;
    assign bl = (cfg.block_len == '0) ? L11'(1) :
                (cfg.block_len > L11'(asws_pkg::MAX_LEN)) ? L11'(asws_pkg::MAX_LEN) :
                cfg.block_len;
    assign rl = (cfg.ring_len == '0) ? L11'(1) :
                (cfg.ring_len > L11'(asws_pkg::RING_DEPTH)) ? L11'(asws_pkg::RING_DEPTH) :
                cfg.ring_len;
    assign wl = (cfg.window_len == '0) ? LEN_W'(1) :
                (LEN_W'(cfg.window_len) > LEN_W'(WINDOW)) ? LEN_W'(WINDOW) :
                LEN_W'(cfg.window_len);

    // Block value
    assign thr    = cfg.large_mode ? (asws_pkg::THR_W'(bl) << v) :
                    ((cfg.block_threshold == '0) ? asws_pkg::THR_W'(1) : cfg.block_threshold);
    assign thr_sh = DV_W'(thr) << QW;

    // Positions, wrapped after a length shrinks
    assign ring_p      = ({1'b0, ring_pos_reg} >= rl) ? '0 : ring_pos_reg;
    assign ring_inc    = L11'(ring_p) + L11'(1);
    assign ring_pos_nx = (ring_inc >= rl) ? '0 : ring_inc[asws_pkg::RING_AW-1:0];
    assign line_p      = (LEN_W'(line_pos_reg) >= wl) ? '0 : line_pos_reg;
    assign line_inc    = LEN_W'(line_p) + LEN_W'(1);
    assign line_pos_nx = (line_inc >= wl) ? '0 : line_inc[LINE_AW-1:0];

    // Residual plus item
    assign tot         = asws_pkg::TOT_W'(res_reg) + asws_pkg::TOT_W'(x_data);
    assign res_add_sat = (tot > asws_pkg::TOT_W'(asws_pkg::RES_MAX)) ? asws_pkg::RES_MAX :
                         tot[asws_pkg::RES_W-1:0];
    assign item_inc    = item_reg + L11'(1);
    assign closing     = item_inc >= bl;
    assign blk_bit     = asws_pkg::THR_W'(res_reg) >= thr;
    assign div_ge      = DV_W'(rem_reg) >= dsor_reg;

    // Count saturation and estimate sum
    assign cnt_ext  = CNT_EXT_W'(count_reg);
    assign cnt_sat  = (cnt_ext > CNT_EXT_W'(asws_pkg::CNT_MAX)) ? asws_pkg::CNT_MAX :
                      cnt_ext[asws_pkg::CNT_W-1:0];
    assign est_sum  = (asws_pkg::PROD_W + 1)'(prod_reg) + (asws_pkg::PROD_W + 1)'(res_reg);
    assign out_free = !out_valid_reg || out_ch.ready;

    assign clr_ring = (CLR_AW + 1)'(clr_reg) < (CLR_AW + 1)'(asws_pkg::RING_DEPTH);
    assign clr_line = (CLR_AW + 1)'(clr_reg) < (CLR_AW + 1)'(WINDOW);

    assign clearing     = (state_reg == asws_pkg::BE_CLEAR);
    assign x_pop        = (state_reg == asws_pkg::BE_IDLE) && x_valid;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.block_count = out_cnt_reg;
    assign out_ch.residual    = out_res_reg;
    assign out_ch.estimate    = out_est_reg;

    // Memory write ports: clearing pass or entry update
    always_comb
    begin
        ring_we    = 1'b0;
        ring_waddr = ring_p;
        ring_wdata = blk_bit;
        line_we    = 1'b0;
        line_waddr = line_p;
        line_wdata = quo_reg;
        case (state_reg)
            asws_pkg::BE_CLEAR:
            begin
                ring_we    = clr_ring;
                ring_waddr = clr_reg[asws_pkg::RING_AW-1:0];
                ring_wdata = 1'b0;
                line_we    = clr_line;
                line_waddr = clr_reg[LINE_AW-1:0];
                line_wdata = '0;
            end
            asws_pkg::BE_LOOK:
            begin
                ring_we = cfg.large_mode;
            end
            asws_pkg::BE_FIN:
            begin
                line_we = 1'b1;
            end
            default:
            begin
                ring_we = 1'b0;
            end
        endcase
    end

    asws_ram #(
        .WIDTH (1),
        .DEPTH (asws_pkg::RING_DEPTH)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_p),
        .rdata (ring_rdata)
    );

    asws_ram #(
        .WIDTH (QW),
        .DEPTH (WINDOW)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .raddr (line_p),
        .rdata (line_rdata)
    );

    // Item sequence
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        rem_next       = rem_reg;
        dsor_next      = dsor_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        item_next      = item_reg;
        ring_pos_next  = ring_pos_reg;
        line_pos_next  = line_pos_reg;
        clr_next       = clr_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_cnt_next   = out_cnt_reg;
        out_res_next   = out_res_reg;
        out_est_next   = out_est_reg;
        case (state_reg)
            asws_pkg::BE_CLEAR:
            begin
                clr_next = clr_reg + CLR_AW'(1);
                if (clr_reg == CLR_AW'(CLR_DEPTH - 1))
                begin
                    state_next = asws_pkg::BE_IDLE;
                end
            end
            asws_pkg::BE_IDLE:
            begin
                if (x_valid)
                begin
                    if (cfg.large_mode)
                    begin
                        res_next = res_add_sat;
                        if (closing)
                        begin
                            item_next  = '0;
                            state_next = asws_pkg::BE_LOOK;
                        end
                        else
                        begin
                            item_next  = item_inc;
                            state_next = asws_pkg::BE_MUL;
                        end
                    end
                    else
                    begin
                        rem_next   = tot;
                        state_next = asws_pkg::BE_LOOK;
                    end
                end
            end
            asws_pkg::BE_LOOK:
            begin
                if (cfg.large_mode)
                begin
                    // Old ring bit leaves, new bit enters
                    count_next = ((ring_rdata && count_reg == '0) ? count_reg :
                                  count_reg - COUNT_W'(ring_rdata)) + COUNT_W'(blk_bit);
                    if (blk_bit)
                    begin
                        res_next = res_reg - asws_pkg::RES_W'(thr);
                    end
                    ring_pos_next = ring_pos_nx;
                    state_next    = asws_pkg::BE_MUL;
                end
                else
                begin
                    count_next = (COUNT_W'(line_rdata) > count_reg) ? '0 :
                                 count_reg - COUNT_W'(line_rdata);
                    if (DV_W'(rem_reg) >= thr_sh)
                    begin
                        // Quotient saturates; residual keeps the rest
                        quo_next   = '1;
                        rem_next   = asws_pkg::TOT_W'(DV_W'(rem_reg) - thr_sh + DV_W'(thr));
                        state_next = asws_pkg::BE_FIN;
                    end
                    else
                    begin
                        quo_next   = '0;
                        dsor_next  = DV_W'(thr) << (QW - 1);
                        step_next  = SW'(QW - 1);
                        state_next = asws_pkg::BE_DIV;
                    end
                end
            end
            asws_pkg::BE_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - asws_pkg::TOT_W'(dsor_reg);
                end
                quo_next  = (quo_reg << 1) | QW'(div_ge);
                dsor_next = dsor_reg >> 1;
                step_next = step_reg - SW'(1);
                if (step_reg == '0)
                begin
                    state_next = asws_pkg::BE_FIN;
                end
            end
            asws_pkg::BE_FIN:
            begin
                res_next = (rem_reg > asws_pkg::TOT_W'(asws_pkg::RES_MAX)) ? asws_pkg::RES_MAX :
                           rem_reg[asws_pkg::RES_W-1:0];
                count_next    = count_reg + COUNT_W'(quo_reg);
                line_pos_next = line_pos_nx;
                state_next    = asws_pkg::BE_MUL;
            end
            asws_pkg::BE_MUL:
            begin
                prod_next  = asws_pkg::PROD_W'(thr) * asws_pkg::PROD_W'(cnt_sat);
                state_next = asws_pkg::BE_EST;
            end
            asws_pkg::BE_EST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_cnt_next   = cnt_sat;
                    out_res_next   = res_reg;
                    out_est_next   = (est_sum > (asws_pkg::PROD_W + 1)'(asws_pkg::EST_MAX)) ?
                                     asws_pkg::EST_MAX : est_sum[asws_pkg::EST_W-1:0];
                    state_next     = asws_pkg::BE_IDLE;
                end
            end
            default:
            begin
                state_next = asws_pkg::BE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= asws_pkg::BE_CLEAR;
            count_reg     <= '0;
            res_reg       <= '0;
            item_reg      <= '0;
            ring_pos_reg  <= '0;
            line_pos_reg  <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_reg       <= res_next;
            item_reg      <= item_next;
            ring_pos_reg  <= ring_pos_next;
            line_pos_reg  <= line_pos_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        dsor_reg    <= dsor_next;
        quo_reg     <= quo_next;
        step_reg    <= step_next;
        prod_reg    <= prod_next;
        out_cnt_reg <= out_cnt_next;
        out_res_reg <= out_res_next;
        out_est_reg <= out_est_next;
    end

endmodule

`default_nettype wire

@@ rtl/approx_sliding_window_sum.sv @@
// Approximate sliding-window sum: each packet size is normalised to
// round(size*2^v/range_max) by a bit-serial divider in the front end. The front
// end accepts an item, forms its 17 quotient bits serially and then hands it off.
// A size whose quotient would overflow skips the division and goes straight to
// the hand-off. A two-entry queue feeds the back end, which updates the residual
// and the block ring (large mode) or quotient line (small mode). With a block
// still open it goes from idle to multiply and estimate; a closing block adds a
// ring look-up, small mode adds a look-up and a finish step, and a full quotient
// division adds QUOTIENT_BITS divide steps before the finish. It holds the result
// in an output register and waits there while the output is stalled. The queue
// lets the front end take new sizes while the back end is still busy.
// After reset the back end clears both memories, during which no packet is
// accepted; configuration writes are taken always.
// Depends on asws_pkg, asws_if, asws_front, asws_queue and asws_back.
`timescale 1ns / 1ps
`default_nettype none

module approx_sliding_window_sum #(
    parameter int WINDOW        = 1024,
    parameter int QUOTIENT_BITS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [asws_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [asws_pkg::CFG_DATA_W-1:0]   cfg_data,
    asws_in_if.sink                                in_ch,
    asws_out_if.source                             out_ch
);

    asws_pkg::cfg_t          cfg_reg, cfg_next;
    logic                    hold;
    logic                    push_valid, push_ready;
    logic [asws_pkg::XW-1:0] push_data;
    logic                    x_valid, x_pop;
    logic [asws_pkg::XW-1:0] x_data;

    // Register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                asws_pkg::CFG_RANGE_MAX:       cfg_next.range_max       = cfg_data[15:0];
                asws_pkg::CFG_PRECISION_BITS:  cfg_next.precision_bits  = cfg_data[4:0];
                asws_pkg::CFG_LARGE_MODE:      cfg_next.large_mode      = cfg_data[0];
                asws_pkg::CFG_BLOCK_LEN:       cfg_next.block_len       = cfg_data[10:0];
                asws_pkg::CFG_RING_LEN:        cfg_next.ring_len        = cfg_data[10:0];
                asws_pkg::CFG_BLOCK_THRESHOLD: cfg_next.block_threshold = cfg_data[26:0];
                asws_pkg::CFG_WINDOW_LEN:      cfg_next.window_len      = cfg_data[10:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_max       <= 16'd1500;
            cfg_reg.precision_bits  <= 5'd8;
            cfg_reg.large_mode      <= 1'b1;
            cfg_reg.block_len       <= 11'd16;
            cfg_reg.ring_len        <= 11'd64;
            cfg_reg.block_threshold <= 27'd256;
            cfg_reg.window_len      <= 11'd1024;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    asws_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg        (cfg_reg),
        .hold       (hold),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    asws_queue #(
        .WIDTH (asws_pkg::XW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (x_pop),
        .pop_data   (x_data),
        .pop_valid  (x_valid)
    );

    asws_back #(
        .WINDOW        (WINDOW),
        .QUOTIENT_BITS (QUOTIENT_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .x_valid  (x_valid),
        .x_data   (x_data),
        .x_pop    (x_pop),
        .out_ch   (out_ch),
        .clearing (hold)
    );

endmodule

`default_nettype wire

@@ sim/tb_approx_sliding_window_sum.sv @@
// Self-checking bench for approx_sliding_window_sum: random packet sizes over
// several register settings, each result checked against an in-bench model.
// Depends on asws_pkg, asws_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_approx_sliding_window_sum;
    import asws_pkg::*;

    typedef struct {
        logic [CNT_W-1:0] block_count;
        logic [RES_W-1:0] residual;
        logic [EST_W-1:0] estimate;
    } window_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    asws_in_if  in_ch ();
    asws_out_if out_ch ();

    approx_sliding_window_sum #(.WINDOW(1024), .QUOTIENT_BITS(8)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    // Clock, 4 ns period
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Model state and register copy
    cfg_t        regs;
    bit          ring_bits [RING_DEPTH];
    int unsigned line_quot [1024];
    longint unsigned count_sum;
    longint unsigned residual_acc;
    int unsigned ring_ptr;
    int unsigned block_fill;
    int unsigned line_ptr;

    logic [SIZE_W-1:0] size_queue [$];
    window_result_t    sums_due [$];
    int  errors;
    bit  calm_in;
    bit  calm_out;
    int  in_gap;
    int  out_stall;

    function automatic longint unsigned clip(longint unsigned x, longint unsigned lo,
                                             longint unsigned hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    // Window sum update for one packet; returns the expected result
    function automatic window_result_t window_step(logic [SIZE_W-1:0] size);
        longint unsigned rng, v, one, x, thr, bl, rl, wl, tot, q, cnt, est;
        int unsigned p;
        window_result_t r;
        rng = clip(regs.range_max, 1, 65535);
        v   = clip(regs.precision_bits, 1, 16);
        one = 64'd1 << v;
        x   = (longint'(size) * one + rng / 2) / rng;
        if (x > one)
            x = one;
        if (regs.large_mode) begin
            bl  = clip(regs.block_len, 1, 1024);
            rl  = clip(regs.ring_len, 1, RING_DEPTH);
            thr = bl << v;
            residual_acc = clip(residual_acc + x, 0, RES_MAX);
            block_fill++;
            if (block_fill >= bl) begin
                p = ring_ptr;
                if (p >= rl)
                    p = 0;
                if (ring_bits[p])
                    count_sum = (count_sum == 0) ? 0 : count_sum - 1;
                ring_bits[p] = (residual_acc >= thr);
                if (ring_bits[p]) begin
                    residual_acc -= thr;
                    count_sum++;
                end
                p++;
                ring_ptr   = (p >= rl) ? 0 : p;
                block_fill = 0;
            end
        end else begin
            wl  = clip(regs.window_len, 1, 1024);
            thr = clip(regs.block_threshold, 1, EST_MAX);
            p   = line_ptr;
            if (p >= wl)
                p = 0;
            count_sum = (line_quot[p] > count_sum) ? 0 : count_sum - line_quot[p];
            tot = residual_acc + x;
            q   = tot / thr;
            if (q > 255)
                q = 255;
            line_quot[p] = q;
            residual_acc = clip(tot - q * thr, 0, RES_MAX);
            count_sum += q;
            p++;
            line_ptr = (p >= wl) ? 0 : p;
        end
        cnt = clip(count_sum, 0, CNT_MAX);
        est = clip(thr * cnt + residual_acc, 0, EST_MAX);
        r.block_count = cnt;
        r.residual    = residual_acc;
        r.estimate    = est;
        return r;
    endfunction

    // Gap length: mostly none or short, a few long; none at all in calm stretches
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Source side: drive items from the queue, model each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_ch.valid       <= 1'b0;
            in_ch.packet_size <= '0;
            in_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                sums_due.push_back(window_step(in_ch.packet_size));
            if (!in_ch.valid || in_ch.ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_ch.valid <= 1'b0;
                end else if (size_queue.size() > 0) begin
                    in_ch.valid       <= 1'b1;
                    in_ch.packet_size <= size_queue.pop_front();
                    in_gap = pick_gap(calm_in);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Sink side: random back-pressure, compare each result
    always @(posedge clk or negedge rst_n)
    begin
        window_result_t e;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            out_stall = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (sums_due.size() == 0) begin
                    $display("%0t: result with none expected: count %0d res %0d est %0d",
                             $time, out_ch.block_count, out_ch.residual, out_ch.estimate);
                    errors++;
                end else begin
                    e = sums_due.pop_front();
                    if (out_ch.block_count !== e.block_count) begin
                        $display("%0t: block_count expected %0d got %0d",
                                 $time, e.block_count, out_ch.block_count);
                        errors++;
                    end
                    if (out_ch.residual !== e.residual) begin
                        $display("%0t: residual expected %0d got %0d",
                                 $time, e.residual, out_ch.residual);
                        errors++;
                    end
                    if (out_ch.estimate !== e.estimate) begin
                        $display("%0t: estimate expected %0d got %0d",
                                 $time, e.estimate, out_ch.estimate);
                        errors++;
                    end
                end
                out_stall = pick_gap(calm_out);
            end
            if (out_stall > 0) begin
                out_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Register write, one per clock; the copy is kept in step
    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_RANGE_MAX:       regs.range_max       = val[15:0];
            CFG_PRECISION_BITS:  regs.precision_bits  = val[4:0];
            CFG_LARGE_MODE:      regs.large_mode      = val[0];
            CFG_BLOCK_LEN:       regs.block_len       = val[10:0];
            CFG_RING_LEN:        regs.ring_len        = val[10:0];
            CFG_BLOCK_THRESHOLD: regs.block_threshold = val[26:0];
            CFG_WINDOW_LEN:      regs.window_len      = val[10:0];
            default: ;
        endcase
    endtask

    // Hold the sender until the block has drained
    task automatic wait_idle();
        while (size_queue.size() > 0 || in_ch.valid || sums_due.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_len();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 1;
            2: return 1024;
            3: return 2047;
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned rng;
        rng = (regs.range_max == 0) ? 1 : regs.range_max;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 65535);
            4, 5:       return $urandom_range(0, rng);
            6:          return (rng > 2) ? rng - $urandom_range(0, 2) : rng;
            7:          return 0;
            8:          return 16'hffff;
            default:    return $urandom_range(0, 31);
        endcase
    endfunction

    // Stimulus sequence
    initial
    begin
        logic [SIZE_W-1:0] directed [] = '{0, 16'hffff, 1500, 749, 750, 751, 1, 3,
                                           16'h8000, 16'h7fff, 1499, 1501, 5, 0,
                                           16'hffff, 16'hffff};
        errors   = 0;
        calm_in  = 1'b0;
        calm_out = 1'b0;
        regs = '{range_max: 1500, precision_bits: 8, large_mode: 1, block_len: 16,
                 ring_len: 64, block_threshold: 256, window_len: 1024};
        count_sum = 0; residual_acc = 0; ring_ptr = 0; block_fill = 0; line_ptr = 0;
        foreach (ring_bits[i]) ring_bits[i] = 1'b0;
        foreach (line_quot[i]) line_quot[i] = 0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_ch.valid        = 1'b0;
        in_ch.packet_size  = '0;
        out_ch.ready       = 1'b0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: rounding around half, saturation, first block close
        foreach (directed[i]) size_queue.push_back(directed[i]);
        wait_idle();

        // Small mode at a threshold of one: quotient saturation
        write_reg(CFG_LARGE_MODE, 0);
        write_reg(CFG_BLOCK_THRESHOLD, 1);
        write_reg(CFG_PRECISION_BITS, 16);
        write_reg(CFG_RANGE_MAX, 1);
        write_reg(CFG_WINDOW_LEN, 0);
        cfg_we <= 1'b0;
        repeat (6) size_queue.push_back(16'hffff);
        size_queue.push_back(0);
        wait_idle();

        // Random settings, extremes among them; lengths shrink and grow across phases
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 3))
                0: write_reg(CFG_RANGE_MAX, 0);
                1: write_reg(CFG_RANGE_MAX, 65535);
                default: write_reg(CFG_RANGE_MAX, $urandom_range(1, 65535));
            endcase
            case ($urandom_range(0, 4))
                0: write_reg(CFG_PRECISION_BITS, 0);
                1: write_reg(CFG_PRECISION_BITS, 16);
                2: write_reg(CFG_PRECISION_BITS, $urandom_range(17, 31));
                default: write_reg(CFG_PRECISION_BITS, $urandom_range(1, 16));
            endcase
            write_reg(CFG_LARGE_MODE, ph % 2);
            write_reg(CFG_BLOCK_LEN, pick_len());
            write_reg(CFG_RING_LEN, pick_len());
            write_reg(CFG_WINDOW_LEN, pick_len());
            case ($urandom_range(0, 4))
                0: write_reg(CFG_BLOCK_THRESHOLD, 0);
                1: write_reg(CFG_BLOCK_THRESHOLD, 27'h7ffffff);
                2: write_reg(CFG_BLOCK_THRESHOLD, $urandom());
                default: write_reg(CFG_BLOCK_THRESHOLD, $urandom_range(1, 4096));
            endcase
            cfg_we <= 1'b0;
            calm_in  = ($urandom_range(0, 3) == 0);
            calm_out = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 150; k++)
                size_queue.push_back(pick_size());
            wait_idle();
        end

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
